// ----- rtl/bsf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_pkg: shared definitions for the bit stuffing frame builder
// frame constants, field widths, bit kinds and the command passed front to back
// ----------------------------------------------------------------------------
package bsf_pkg;

    // consecutive payload ones that force a stuffed zero (2..7)
    localparam int STUFF_RUN    = 5;
    // address bits sent after the opening flag (1..8)
    localparam int ADDRESS_BITS = 3;

    localparam int DEST_W  = 3;
    localparam int ONES_W  = 3;
    localparam int FLAG_W  = 8;
    localparam int IDX_W   = 3;
    localparam int KIND_W  = 2;

    localparam logic [FLAG_W-1:0] FLAG_PATTERN = 8'h7E;

    localparam logic [KIND_W-1:0] KIND_FLAG  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADDR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STUFF = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified payload beat, ready for serialization
    typedef struct packed {
        logic              data_bit;
        logic              is_start;
        logic              is_end;
        logic              do_stuff;
        logic [DEST_W-1:0] addr;
    } t_cmd;

endpackage

// ----- rtl/bsf_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_ifs: valid/ready channels of the frame builder
// input channel carries payload beats, output channel carries line bits
// ----------------------------------------------------------------------------
interface bsf_in_if;
    logic       valid;
    logic       ready;
    logic       payload_bit;
    logic       frame_start;
    logic       frame_end;
    logic [2:0] dest_address;

    modport source (output valid, output payload_bit, output frame_start,
                    output frame_end, output dest_address, input ready);
    modport sink   (input valid, input payload_bit, input frame_start,
                    input frame_end, input dest_address, output ready);
endinterface

interface bsf_out_if;
    logic       valid;
    logic       ready;
    logic       line_bit;
    logic [1:0] bit_kind;
    logic       run_last;
    logic       frame_closed;

    modport source (output valid, output line_bit, output bit_kind,
                    output run_last, output frame_closed, input ready);
    modport sink   (input valid, input line_bit, input bit_kind,
                    input run_last, input frame_closed, output ready);
endinterface

// ----- rtl/bsf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_front: input classifier
// tracks frame state and the ones run, decides stuffing, queues commands
// ----------------------------------------------------------------------------
module bsf_front
    import bsf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    bsf_in_if.sink  i_in,
    input  logic    i_full,
    output logic    o_push,
    output t_cmd    o_cmd
);

    logic              r_open;
    logic              n_open;
    logic [ONES_W-1:0] r_ones;
    logic [ONES_W-1:0] n_ones;
    logic [ONES_W-1:0] w_base;
    logic [ONES_W-1:0] w_run;
    logic              w_accept;
    logic              w_stuff;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        w_base  = i_in.frame_start ? '0 : r_ones;
        w_run   = i_in.payload_bit ? ONES_W'(w_base + 1'b1) : '0;
        w_stuff = (w_run == ONES_W'(STUFF_RUN));
        n_ones  = r_ones;
        n_open  = r_open;
        o_push  = 1'b0;
        // beats outside a frame are swallowed
        if (w_accept && (i_in.frame_start || r_open)) begin
            o_push = 1'b1;
            n_ones = w_stuff ? '0 : w_run;
            n_open = !i_in.frame_end;
        end
    end

    assign o_cmd.data_bit = i_in.payload_bit;
    assign o_cmd.is_start = i_in.frame_start;
    assign o_cmd.is_end   = i_in.frame_end;
    assign o_cmd.do_stuff = w_stuff;
    assign o_cmd.addr     = i_in.dest_address;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_ones <= '0;
        end else begin
            r_open <= n_open;
            r_ones <= n_ones;
        end
    end

endmodule

// ----- rtl/bsf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_queue: command queue
// small flop fifo between classifier and serializer, head shown directly
// ----------------------------------------------------------------------------
module bsf_queue
    import bsf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head,
    input  logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= QPTR_W'(r_wr + 1'b1);
            end
            if (w_pop) begin
                r_rd <= QPTR_W'(r_rd + 1'b1);
            end
            if (i_push && !w_pop) begin
                r_cnt <= QCNT_W'(r_cnt + 1'b1);
            end else if (!i_push && w_pop) begin
                r_cnt <= QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

endmodule

// ----- rtl/bsf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_back: line serializer
// walks a command: start flag, address; data; stuff if set; at end closing flag
// ----------------------------------------------------------------------------
module bsf_back
    import bsf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_cmd     i_head,
    output logic     o_pop,
    bsf_out_if.source o_out
);

    localparam logic [2:0] PH_OPEN  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_STUFF = 3'd3;
    localparam logic [2:0] PH_CLOSE = 3'd4;

    logic              r_mid;
    logic [2:0]        r_phase;
    logic [IDX_W-1:0]  r_idx;
    logic [2:0]        n_phase;
    logic [IDX_W-1:0]  n_idx;
    logic [2:0]        w_phase;
    logic [IDX_W-1:0]  w_idx;
    logic [IDX_W-1:0]  w_ai;
    logic              w_bit;
    logic [KIND_W-1:0] w_kind;
    logic              w_last;
    logic              w_closed;
    logic              w_adv;
    logic              w_step;

    logic              r_ov;
    logic              r_bit;
    logic [KIND_W-1:0] r_kind;
    logic              r_last;
    logic              r_closed;

    assign w_phase = r_mid ? r_phase : (i_head.is_start ? PH_OPEN : PH_DATA);
    assign w_idx   = r_mid ? r_idx : '0;
    assign w_ai    = IDX_W'(ADDRESS_BITS - 1) - w_idx;

    always_comb begin
        w_bit    = 1'b0;
        w_kind   = KIND_FLAG;
        w_last   = 1'b0;
        w_closed = 1'b0;
        n_phase  = w_phase;
        n_idx    = IDX_W'(w_idx + 1'b1);
        case (w_phase)
            PH_OPEN: begin
                w_bit = FLAG_PATTERN[IDX_W'(FLAG_W - 1) - w_idx];
                if (w_idx == IDX_W'(FLAG_W - 1)) begin
                    n_phase = PH_ADDR;
                    n_idx   = '0;
                end
            end
            PH_ADDR: begin
                w_kind = KIND_ADDR;
                // address bits above the field width go out as zero
                w_bit  = (w_ai < IDX_W'(DEST_W)) ? i_head.addr[w_ai[1:0]] : 1'b0;
                if (w_idx == IDX_W'(ADDRESS_BITS - 1)) begin
                    n_phase = PH_DATA;
                    n_idx   = '0;
                end
            end
            PH_DATA: begin
                w_kind = KIND_DATA;
                w_bit  = i_head.data_bit;
                n_idx  = '0;
                if (i_head.do_stuff) begin
                    n_phase = PH_STUFF;
                end else if (i_head.is_end) begin
                    n_phase = PH_CLOSE;
                end else begin
                    w_last = 1'b1;
                end
            end
            PH_STUFF: begin
                w_kind = KIND_STUFF;
                n_idx  = '0;
                if (i_head.is_end) begin
                    n_phase = PH_CLOSE;
                end else begin
                    w_last = 1'b1;
                end
            end
            PH_CLOSE: begin
                w_bit = FLAG_PATTERN[IDX_W'(FLAG_W - 1) - w_idx];
                if (w_idx == IDX_W'(FLAG_W - 1)) begin
                    w_last   = 1'b1;
                    w_closed = 1'b1;
                end
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
    end

    assign w_adv  = !r_ov || o_out.ready;
    assign w_step = w_adv && i_valid;
    assign o_pop  = w_step && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= 1'b0;
            r_phase <= PH_OPEN;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_step) begin
                r_mid   <= !w_last;
                r_phase <= n_phase;
                r_idx   <= n_idx;
            end
            if (w_adv) begin
                r_ov <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_bit    <= w_bit;
            r_kind   <= w_kind;
            r_last   <= w_last;
            r_closed <= w_closed;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.line_bit     = r_bit;
    assign o_out.bit_kind     = r_kind;
    assign o_out.run_last     = r_last;
    assign o_out.frame_closed = r_closed;

endmodule

// ----- rtl/bit_stuffing_frame_builder.sv -----
`timescale 1ns / 1ps
// path: an accepted beat is written to the command queue, then its first line bit is registered at the output
// throughput: one line bit per cycle while the output is ready and a command waits;
//   a plain payload beat gives one line bit, a frame start adds 8 flag + ADDRESS_BITS
//   address bits, a stuffed zero one bit, a frame end 8 flag bits
// reset: synchronous active-low i_rst_n clears frame state, run count,
//   queue, serializer state and output valid flag; no clearing pass
// ----------------------------------------------------------------------------
// bit_stuffing_frame_builder: hdlc-style serial framer
// wraps payload bits in flags and address and inserts stuffed zeros
// ----------------------------------------------------------------------------
module bit_stuffing_frame_builder
    import bsf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsf_in_if.sink    i_in,
    bsf_out_if.source o_out
);

    // front to queue
    logic w_push;
    t_cmd w_cmd;
    logic w_full;

    // queue to back
    logic w_head_valid;
    t_cmd w_head;
    logic w_pop;

    // classifier: frame tracking, ones run, stuffing decision per beat
    bsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    // decouples the input, one beat per cycle while the queue is not full, from multi-bit serialization
    bsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // serializer with registered output, pops a command on its last line bit
    bsf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_head_valid),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
